// ----- rtl/core/svi_pkg.sv -----
// Shared types, constants and the CRC byte step for the staged image verifier.
`timescale 1ns / 1ps
`default_nettype none

package svi_pkg;

    // Reflected CRC-32 constants
    localparam logic [31:0] CRC_POLY     = 32'hEDB8_8320;
    localparam logic [31:0] CRC_PRESET   = 32'hFFFF_FFFF;

    // Vector table match masks (stack pointer and reset vector words)
    localparam logic [31:0] SP_MASK      = 32'h2FFE_0000;
    localparam logic [31:0] SP_VALUE     = 32'h2000_0000;
    localparam logic [31:0] PC_MASK      = 32'hFF00_0000;
    localparam logic [31:0] PC_VALUE     = 32'h0800_0000;

    // Register defaults
    localparam logic [31:0] EXP_CRC_RST  = 32'h0000_0000;
    localparam logic [23:0] APP_SIZE_RST = 24'h01_0000;

    // Register map: byte address bits [2:0], index on bit 2
    localparam int          PADDR_W      = 3;
    localparam logic        REG_EXP_CRC  = 1'b0;
    localparam logic        REG_APP_SIZE = 1'b1;

    // Result status codes
    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_NO_TABLE = 2'd1,
        ST_CRC_BAD  = 2'd2
    } t_status;

    // Input transfer payload
    typedef struct packed {
        logic [7:0] data_byte;
        logic       last;
    } t_in_item;

    // Result transfer payload
    typedef struct packed {
        logic [1:0]  status;
        logic [23:0] image_start;
        logic [23:0] payload_length;
        logic [31:0] computed_crc;
    } t_out_item;

    // Configuration values handed to the datapath
    typedef struct packed {
        logic [31:0] expected_crc;
        logic [23:0] app_size_limit;
    } t_cfg;

    // One byte of reflected CRC-32, eight bit steps unrolled
    function automatic logic [31:0] crc32_byte(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {24'h0, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/core/svi_cfg_regs.sv -----
// APB-style configuration registers for the staged image verifier.
`timescale 1ns / 1ps
`default_nettype none

module svi_cfg_regs (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [svi_pkg::PADDR_W-1:0] paddr,
    input  wire logic [31:0]                 pwdata,
    output logic [31:0]                      prdata,
    output logic                             pready,
    output svi_pkg::t_cfg                    o_cfg
);
    import svi_pkg::*;

    logic [31:0] r_expected_crc;
    logic [23:0] r_app_size_limit;
    logic        wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    // Register writes in the access phase
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_expected_crc   <= EXP_CRC_RST;
            r_app_size_limit <= APP_SIZE_RST;
        end else if (wr_en) begin
            case (paddr[2])
                REG_EXP_CRC:  r_expected_crc   <= pwdata;
                REG_APP_SIZE: r_app_size_limit <= pwdata[23:0];
                default:      ;
            endcase
        end
    end

    // Read mux
    always_comb begin
        case (paddr[2])
            REG_EXP_CRC:  prdata = r_expected_crc;
            REG_APP_SIZE: prdata = {8'h0, r_app_size_limit};
            default:      prdata = 32'h0;
        endcase
    end

    assign o_cfg.expected_crc   = r_expected_crc;
    assign o_cfg.app_size_limit = r_app_size_limit;

endmodule

`default_nettype wire

// ----- rtl/core/staged_image_verifier_top.sv -----
// Staged image verifier top level: byte stream in, one check result per image out.
// Usage:
//   Input channel: one image byte per transfer (i_in_valid / o_in_stall), the
//   last field marks the final byte of an image.
//   Output channel: one result per image (o_out_valid / i_out_stall) with
//   status, vector table offset, clipped payload length and the CRC-32.
//   Config: expected_crc at address 0, app_size_limit at address 4; write
//   only while no image is in flight.
// Timing:
//   A byte is registered on entry and processed from the input register: CRC
//   byte step, 8-byte window compare and count update sit between the input
//   register and the result register. The result register loads when the
//   final byte is processed. One byte per cycle is sustained; the input stalls
//   only when a final byte waits for a result register that is still full.
// Reset: clears the CRC, window, count and found flag of the current image,
//   empties both registers, and returns config to its defaults.
// Receiver stall: the result holds; non-final bytes keep flowing.
`timescale 1ns / 1ps
`default_nettype none

module staged_image_verifier_top #(
    parameter int COUNT_WIDTH = 24
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    // Input byte channel
    input  wire logic                        i_in_valid,
    output logic                             o_in_stall,
    input  wire svi_pkg::t_in_item           i_in_item,
    // Result channel
    output logic                             o_out_valid,
    input  wire logic                        i_out_stall,
    output svi_pkg::t_out_item               o_out_item,
    // Configuration port
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [svi_pkg::PADDR_W-1:0] paddr,
    input  wire logic [31:0]                 pwdata,
    output logic [31:0]                      prdata,
    output logic                             pready
);
    import svi_pkg::*;

    localparam int                   LEN_W     = (COUNT_WIDTH > 24) ? COUNT_WIDTH : 24;
    localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {COUNT_WIDTH{1'b1}};
    localparam logic [COUNT_WIDTH-1:0] WIN_SPAN = COUNT_WIDTH'(7);

    t_cfg cfg;

    svi_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // Input register
    logic                   r_in_valid;
    t_in_item               r_in_item;
    // Per-image scan state
    logic [31:0]            r_crc;
    logic [55:0]            r_window;
    logic [COUNT_WIDTH-1:0] r_count;
    logic                   r_found;
    logic [COUNT_WIDTH-1:0] r_start;
    // Result register
    logic                   r_out_valid;
    t_out_item              r_out_item;

    logic                   in_take;
    logic                   out_free;
    logic                   proc_en;

    logic [31:0]            n_crc;
    logic [63:0]            n_window_full;
    logic                   match;
    logic                   n_found;
    logic [COUNT_WIDTH-1:0] n_start;
    logic [COUNT_WIDTH-1:0] n_count;
    logic [COUNT_WIDTH-1:0] len_raw;
    logic [LEN_W-1:0]       len_ext;
    logic [LEN_W-1:0]       limit_ext;
    logic [LEN_W-1:0]       start_ext;
    logic [LEN_W-1:0]       len_clip;
    logic [31:0]            final_crc;
    t_out_item              n_out_item;

    // Handshake: a final byte needs a free result register to move on
    assign out_free   = !r_out_valid || !i_out_stall;
    assign proc_en    = r_in_valid && (!r_in_item.last || out_free);
    assign o_in_stall = r_in_valid && !proc_en;
    assign in_take    = i_in_valid && !o_in_stall;

    // CRC step and window compare on the registered byte
    always_comb begin
        n_crc         = crc32_byte(r_crc, r_in_item.data_byte);
        n_window_full = {r_in_item.data_byte, r_window};
        match         = !r_found && (r_count >= WIN_SPAN)
                     && ((n_window_full[31:0] & SP_MASK) == SP_VALUE)
                     && ((n_window_full[63:32] & PC_MASK) == PC_VALUE);
        n_found       = r_found || match;
        n_start       = match ? (r_count - WIN_SPAN) : r_start;
        n_count       = (r_count == CNT_MAX) ? CNT_MAX : (r_count + 1'b1);
    end

    // Result fields for a final byte
    always_comb begin
        final_crc = ~n_crc;
        len_raw   = n_count - n_start;
        len_ext   = LEN_W'(len_raw);
        limit_ext = LEN_W'(cfg.app_size_limit);
        start_ext = LEN_W'(n_start);
        len_clip  = (len_ext > limit_ext) ? limit_ext : len_ext;
        n_out_item.computed_crc = final_crc;
        if (!n_found) begin
            n_out_item.status         = ST_NO_TABLE;
            n_out_item.image_start    = 24'h0;
            n_out_item.payload_length = 24'h0;
        end else begin
            n_out_item.status         = (final_crc != cfg.expected_crc) ? ST_CRC_BAD : ST_OK;
            n_out_item.image_start    = start_ext[23:0];
            n_out_item.payload_length = len_clip[23:0];
        end
    end

    // Input register control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (proc_en) begin
            r_in_valid <= 1'b0;
        end
    end

    // Input payload
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_item <= i_in_item;
        end
    end

    // Scan state; cleared after each final byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc    <= CRC_PRESET;
            r_window <= 56'h0;
            r_count  <= '0;
            r_found  <= 1'b0;
            r_start  <= '0;
        end else if (proc_en) begin
            if (r_in_item.last) begin
                r_crc    <= CRC_PRESET;
                r_window <= 56'h0;
                r_count  <= '0;
                r_found  <= 1'b0;
                r_start  <= '0;
            end else begin
                r_crc    <= n_crc;
                r_window <= n_window_full[63:8];
                r_count  <= n_count;
                r_found  <= n_found;
                r_start  <= n_start;
            end
        end
    end

    // Result register control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (proc_en && r_in_item.last) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    // Result payload
    always_ff @(posedge i_clk) begin
        if (proc_en && r_in_item.last) begin
            r_out_item <= n_out_item;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

`default_nettype wire

// ----- bench/staged_image_verifier_checker.sv -----
// Checker for the staged image verifier: tracks config, predicts each image verdict, compares.
`timescale 1ns / 1ps

module staged_image_verifier_checker (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    input  wire logic               i_in_stall,
    input  wire svi_pkg::t_in_item  i_in_item,
    input  wire logic               i_out_valid,
    input  wire logic               i_out_stall,
    input  wire svi_pkg::t_out_item i_out_item,
    input  wire logic               i_psel,
    input  wire logic               i_penable,
    input  wire logic               i_pwrite,
    input  wire logic [2:0]         i_paddr,
    input  wire logic [31:0]        i_pwdata,
    input  wire logic [31:0]        i_prdata,
    input  wire logic               i_pready,
    output int                      o_fail_count,
    output int                      o_pending
);
    import svi_pkg::*;

    localparam logic [23:0] COUNT_SAT = '1;

    // Shadow registers
    logic [31:0] shadow_exp_crc;
    logic [23:0] shadow_size_limit;

    // Running image state
    logic [31:0] crc_acc;
    logic [55:0] tail_bytes;
    logic [23:0] bytes_seen;
    logic        table_seen;
    logic [23:0] table_ofs;

    t_out_item   pending_verdicts[$];
    int          fails = 0;

    // Reflected CRC-32, feeding one data bit per shift
    function automatic logic [31:0] crc_update(input logic [31:0] acc, input logic [7:0] b);
        logic [31:0] r;
        r = acc;
        for (int i = 0; i < 8; i++) begin
            if (r[0] ^ b[i]) begin
                r = (r >> 1) ^ CRC_POLY;
            end else begin
                r = r >> 1;
            end
        end
        return r;
    endfunction

    task automatic clear_image();
        crc_acc    = CRC_PRESET;
        tail_bytes = '0;
        bytes_seen = '0;
        table_seen = 1'b0;
        table_ofs  = '0;
    endtask

    task automatic note_fail(input string msg);
        fails++;
        if (fails <= 10) begin
            $display("%0t: %s", $realtime, msg);
        end
    endtask

    // Advance the image state by one byte; on the final byte queue the verdict
    task automatic absorb_byte(input t_in_item it);
        logic [63:0] w;
        logic [31:0] sp;
        logic [31:0] pc;
        logic [23:0] total;
        logic [23:0] len;
        t_out_item   v;
        crc_acc = crc_update(crc_acc, it.data_byte);
        w  = {it.data_byte, tail_bytes};
        sp = w[31:0];
        pc = w[63:32];
        if (!table_seen && bytes_seen >= 24'd7 &&
            (sp & SP_MASK) == SP_VALUE && (pc & PC_MASK) == PC_VALUE) begin
            table_seen = 1'b1;
            table_ofs  = bytes_seen - 24'd7;
        end
        tail_bytes = w[63:8];
        total      = (bytes_seen != COUNT_SAT) ? bytes_seen + 24'd1 : COUNT_SAT;
        bytes_seen = total;
        if (it.last) begin
            v.computed_crc = ~crc_acc;
            if (!table_seen) begin
                v.status         = ST_NO_TABLE;
                v.image_start    = '0;
                v.payload_length = '0;
            end else begin
                len = total - table_ofs;
                if (len > shadow_size_limit) begin
                    len = shadow_size_limit;
                end
                v.status         = (~crc_acc != shadow_exp_crc) ? ST_CRC_BAD : ST_OK;
                v.image_start    = table_ofs;
                v.payload_length = len;
            end
            pending_verdicts.push_back(v);
            clear_image();
        end
    endtask

    task automatic check_result(input t_out_item got);
        t_out_item want;
        if (pending_verdicts.size() == 0) begin
            note_fail($sformatf("unexpected result: status=%0d start=%0d len=%0d crc=%08h",
                                got.status, got.image_start, got.payload_length,
                                got.computed_crc));
        end else begin
            want = pending_verdicts.pop_front();
            if (got.status !== want.status || got.image_start !== want.image_start ||
                got.payload_length !== want.payload_length ||
                got.computed_crc !== want.computed_crc) begin
                note_fail($sformatf({"result mismatch: exp status=%0d start=%0d len=%0d ",
                                     "crc=%08h, got status=%0d start=%0d len=%0d crc=%08h"},
                                    want.status, want.image_start, want.payload_length,
                                    want.computed_crc, got.status, got.image_start,
                                    got.payload_length, got.computed_crc));
            end
        end
    endtask

    // Watch config, both channels and register reads
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            shadow_exp_crc    = EXP_CRC_RST;
            shadow_size_limit = APP_SIZE_RST;
            clear_image();
            pending_verdicts.delete();
        end else begin
            if (i_psel && i_penable && i_pready) begin
                if (i_pwrite) begin
                    if (i_paddr[2] == REG_EXP_CRC) begin
                        shadow_exp_crc = i_pwdata;
                    end else begin
                        shadow_size_limit = i_pwdata[23:0];
                    end
                end else if (i_paddr[2] == REG_EXP_CRC && i_prdata !== shadow_exp_crc) begin
                    note_fail($sformatf("expected_crc read: exp %08h got %08h",
                                        shadow_exp_crc, i_prdata));
                end else if (i_paddr[2] == REG_APP_SIZE &&
                             i_prdata !== {8'h00, shadow_size_limit}) begin
                    note_fail($sformatf("app_size_limit read: exp %08h got %08h",
                                        {8'h00, shadow_size_limit}, i_prdata));
                end
            end
            if (i_in_valid && !i_in_stall) begin
                absorb_byte(i_in_item);
            end
            if (i_out_valid && !i_out_stall) begin
                check_result(i_out_item);
            end
        end
        o_fail_count <= fails;
        o_pending    <= pending_verdicts.size();
    end

endmodule

// ----- bench/staged_image_verifier_top_test.sv -----
// Testbench top for the staged image verifier: clock, reset, image stimulus and verdict.
`timescale 1ns / 1ps

module staged_image_verifier_top_test;
    import svi_pkg::*;

    localparam logic [2:0] ADDR_EXP_CRC  = {REG_EXP_CRC, 2'b00};
    localparam logic [2:0] ADDR_APP_SIZE = {REG_APP_SIZE, 2'b00};
    localparam int         BYTES_PER_PHASE = 350;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    t_in_item    i_in_item = '0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    t_out_item   o_out_item;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    int          fail_count;
    int          pending;
    int          gap_pct = 0;
    int          stall_pct = 0;
    int          bytes_sent = 0;
    logic [7:0]  img[$];

    staged_image_verifier_top i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    staged_image_verifier_checker i_chk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_stall   (o_in_stall),
        .i_in_item    (i_in_item),
        .i_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .i_out_item   (o_out_item),
        .i_psel       (psel),
        .i_penable    (penable),
        .i_pwrite     (pwrite),
        .i_paddr      (paddr),
        .i_pwdata     (pwdata),
        .i_prdata     (prdata),
        .i_pready     (pready),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // Hard stop well beyond the slowest legal run
    initial begin
        #2_000_000;
        $display("staged_image_verifier_top_test: FAIL");
        $finish;
    end

    // Receiver stall pattern
    always @(posedge i_clk) begin
        i_out_stall <= ($urandom_range(0, 99) < stall_pct);
    end

    // One byte transfer, with random sender gaps ahead of it
    task automatic put_byte(input logic [7:0] b, input logic lst);
        while ($urandom_range(0, 99) < gap_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid          <= 1'b1;
        i_in_item.data_byte <= b;
        i_in_item.last      <= lst;
        do @(posedge i_clk); while (o_in_stall);
        bytes_sent++;
    endtask

    // Stop sending and let every outstanding result come back
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (6) @(posedge i_clk);
    endtask

    task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic apb_read(input logic [2:0] addr);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= addr;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic add_random(input int n);
        for (int i = 0; i < n; i++) begin
            img.push_back(8'($urandom));
        end
    endtask

    // Stack pointer and reset vector words, little endian; broken ones miss by one masked bit
    task automatic add_table(input bit broken);
        logic [31:0] sp;
        logic [31:0] pc;
        sp = ($urandom & ~SP_MASK) | SP_VALUE;
        pc = ($urandom & ~PC_MASK) | PC_VALUE;
        if (broken) begin
            if ($urandom_range(0, 1)) begin
                pc = pc ^ (32'h1 << $urandom_range(24, 31));
            end else begin
                sp = sp ^ (32'h1 << $urandom_range(17, 27));
            end
        end
        for (int i = 0; i < 4; i++) img.push_back(sp[8*i +: 8]);
        for (int i = 0; i < 4; i++) img.push_back(pc[8*i +: 8]);
    endtask

    // Send the image in img; optionally program its true CRC first
    task automatic send_image(input bit match_crc);
        logic [31:0] acc;
        if (match_crc) begin
            wait_drained();
            acc = CRC_PRESET;
            foreach (img[i]) acc = crc32_byte(acc, img[i]);
            apb_write(ADDR_EXP_CRC, ~acc);
        end
        foreach (img[i]) put_byte(img[i], i == img.size() - 1);
        img.delete();
    endtask

    // Random image: mostly well formed, some broken tables, noise and short ones
    task automatic build_image();
        int k;
        k = $urandom_range(0, 15);
        if (k <= 9) begin
            add_random($urandom_range(0, 12));
            add_table(1'b0);
            if ($urandom_range(0, 7) == 0) begin
                add_random($urandom_range(40, 120));
            end else begin
                add_random($urandom_range(0, 15));
            end
        end else if (k <= 11) begin
            add_random($urandom_range(0, 6));
            add_table(1'b1);
            if ($urandom_range(0, 1)) add_table(1'b0);
            add_random($urandom_range(0, 6));
        end else if (k <= 13) begin
            add_random($urandom_range(1, 24));
        end else begin
            add_random($urandom_range(1, 7));
        end
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset values of both registers
        apb_read(ADDR_EXP_CRC);
        apb_read(ADDR_APP_SIZE);

        // Table exactly filling the image, ending on the final byte, CRC correct
        img = '{8'h00, 8'h10, 8'h00, 8'h20, 8'h01, 8'h01, 8'h00, 8'h08};
        send_image(1'b1);

        // Zero size limit; one-byte image, table at offset one with bad CRC, two bytes
        wait_drained();
        apb_write(ADDR_APP_SIZE, 32'h0);
        img = '{8'h00};
        send_image(1'b0);
        img = '{8'hA5, 8'h00, 8'h10, 8'h00, 8'h20, 8'h01, 8'h01, 8'h00, 8'h08};
        send_image(1'b0);
        img = '{8'hFF, 8'h80};
        send_image(1'b0);

        for (int ph = 0; ph < 4; ph++) begin
            wait_drained();
            case (ph)
                0: begin
                    gap_pct   = 0;
                    stall_pct = 0;
                    apb_write(ADDR_EXP_CRC, 32'h0);
                    apb_write(ADDR_APP_SIZE, 32'h00FF_FFFF);
                end
                1: begin
                    gap_pct   = 84;
                    stall_pct = 0;
                    apb_write(ADDR_EXP_CRC, 32'hFFFF_FFFF);
                    apb_write(ADDR_APP_SIZE, 32'd16);
                end
                2: begin
                    gap_pct   = 0;
                    stall_pct = 84;
                    apb_write(ADDR_EXP_CRC, $urandom);
                    apb_write(ADDR_APP_SIZE, $urandom_range(0, 64));
                end
                default: begin
                    gap_pct   = 6;
                    stall_pct = 6;
                    apb_write(ADDR_EXP_CRC, $urandom);
                    apb_write(ADDR_APP_SIZE, {8'h00, APP_SIZE_RST});
                end
            endcase
            apb_read(ADDR_EXP_CRC);
            apb_read(ADDR_APP_SIZE);

            // Table at offset 252 of the image, straddling byte 256
            if (ph == 0) begin
                add_random(252);
                add_table(1'b0);
                add_random(3);
                send_image(1'b1);
            end

            while (bytes_sent < 30 + BYTES_PER_PHASE * (ph + 1)) begin
                build_image();
                send_image($urandom_range(0, 3) == 0);
            end
        end

        wait_drained();
        repeat (4) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("staged_image_verifier_top_test: PASS");
        end else begin
            $display("staged_image_verifier_top_test: FAIL");
        end
        $finish;
    end

endmodule
